// ===== rtl/lru_key_value_cache_top_macros.svh =====
// Assertion macros shared by the cache checker.
// Include guard only; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

// implication checked at every clock edge outside reset
`define LKV_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define LKV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lkv_pkg.sv =====
// Types and constants for the LRU key/value cache.
// No dependencies.
package lkv_pkg;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [63:0] entry_in;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] entry_out;
        logic        evicted;
        logic [6:0]  occupancy;
        logic [31:0] query_count;
        logic [31:0] hit_count;
        logic [31:0] eviction_count;
    } out_item_t;

    // controls broadcast to every cell of the recency chain
    typedef struct packed {
        logic clear;
        logic take_all;
        logic take_hit;
    } cell_ctrl_t;

    localparam logic [6:0] CAP_RESET = 7'd64;

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
// LRU key/value cache top: control, counters and the chain of lkv_cell slots.
// Depends on lkv_pkg and lkv_cell.
//
// Usage: operations arrive on s_valid/s_ready/s_data (lookup, insert, clear)
// and each gives exactly one result on m_valid/m_ready/m_data. Slots form a
// chain ordered by recency, slot 0 most recent; all slots compare the key at
// once and shift toward the tail as entries are promoted or inserted.
// The result is registered and presented in the cycle after the input transfer.
// Throughput: one operation per cycle while the receiver takes results; the
// key compare and the hit-position chain through all slots are combinational.
// s_ready is high whenever the output register is empty or being taken, so
// a stalled receiver holds the result and blocks only the next transfer.
// User writes capacity_in_use via cfg_wr_en/cfg_wr_data while idle; not enforced.
// Reset (aresetn low, synchronous) empties all slots, zeroes counters and
// sets capacity_in_use to 64. No clearing pass is needed.
module lru_key_value_cache_top #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 64,
    parameter int COUNTER_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  lkv_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lkv_pkg::out_item_t  m_data
);
    import lkv_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CW    = OCC_W + 8;

    logic [6:0]              cap_reg;
    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic [COUNTER_BITS-1:0] qcnt_reg, qcnt_next;
    logic [COUNTER_BITS-1:0] hcnt_reg, hcnt_next;
    logic [COUNTER_BITS-1:0] ecnt_reg, ecnt_next;
    logic                    m_valid_reg;
    out_item_t               m_data_reg, m_data_next;

    logic                    xfer;
    logic                    is_lookup, is_insert, is_clear;
    logic                    found, evict, store_new;
    logic [CW-1:0]           cap_eff, need;
    logic [PAYLOAD_BITS-1:0] hit_payload, head_payload;
    cell_ctrl_t              ctrl;

    logic                    c_valid   [CAPACITY];
    logic [63:0]             c_key     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] c_payload [CAPACITY];
    logic                    c_match   [CAPACITY];
    logic                    c_found   [CAPACITY+1];
    logic                    c_kill    [CAPACITY];

    assign s_ready   = !m_valid_reg || m_ready;
    assign xfer      = s_valid && s_ready;
    assign is_lookup = (s_data.kind == KIND_LOOKUP);
    assign is_insert = (s_data.kind == KIND_INSERT);
    assign is_clear  = (s_data.kind == KIND_CLEAR);
    assign found     = c_found[0];

    assign cap_eff = (CW'(cap_reg) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_reg);
    assign need    = CW'(occ_reg) + CW'(1);
    assign evict   = is_insert && !found && (need > cap_eff);
    // with an empty store an evicting insert is dropped outright
    assign store_new = is_insert && !found && !(evict && (occ_reg == '0));

    assign ctrl.clear    = xfer && is_clear;
    assign ctrl.take_all = xfer && store_new;
    assign ctrl.take_hit = xfer && found && (is_lookup || is_insert);

    always_comb begin
        hit_payload = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_payload = hit_payload | (c_payload[i] & {PAYLOAD_BITS{c_match[i]}});
        end
    end

    assign head_payload = is_insert ? s_data.entry_in[PAYLOAD_BITS-1:0] : hit_payload;
    assign c_found[CAPACITY] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            // after the shift the oldest entry sits one past the old tail
            assign c_kill[g] = ctrl.take_all && evict && (occ_reg == OCC_W'(g));
            if (g == 0) begin : g_head
                lkv_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .ctrl         (ctrl),
                    .kill         (c_kill[g]),
                    .query_key    (s_data.key),
                    .prev_valid   (1'b1),
                    .prev_key     (s_data.key),
                    .prev_payload (head_payload),
                    .found_in     (c_found[g+1]),
                    .found_out    (c_found[g]),
                    .match        (c_match[g]),
                    .valid        (c_valid[g]),
                    .key          (c_key[g]),
                    .payload      (c_payload[g])
                );
            end else begin : g_body
                lkv_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .ctrl         (ctrl),
                    .kill         (c_kill[g]),
                    .query_key    (s_data.key),
                    .prev_valid   (c_valid[g-1]),
                    .prev_key     (c_key[g-1]),
                    .prev_payload (c_payload[g-1]),
                    .found_in     (c_found[g+1]),
                    .found_out    (c_found[g]),
                    .match        (c_match[g]),
                    .valid        (c_valid[g]),
                    .key          (c_key[g]),
                    .payload      (c_payload[g])
                );
            end
        end
    endgenerate

    always_comb begin
        logic [OCC_W+6:0]        occ_ext;
        logic [COUNTER_BITS+31:0] q_ext, h_ext, e_ext;
        logic [PAYLOAD_BITS+63:0] p_ext;
        qcnt_next = qcnt_reg;
        hcnt_next = hcnt_reg;
        ecnt_next = ecnt_reg;
        occ_next  = occ_reg;
        if (is_clear) begin
            qcnt_next = '0;
            hcnt_next = '0;
            ecnt_next = '0;
            occ_next  = '0;
        end else begin
            if (is_lookup && qcnt_reg != '1) begin
                qcnt_next = qcnt_reg + COUNTER_BITS'(1);
            end
            if (is_lookup && found && hcnt_reg != '1) begin
                hcnt_next = hcnt_reg + COUNTER_BITS'(1);
            end
            if (evict && ecnt_reg != '1) begin
                ecnt_next = ecnt_reg + COUNTER_BITS'(1);
            end
            if (store_new && !evict) begin
                occ_next = occ_reg + OCC_W'(1);
            end
        end
        occ_ext = {7'd0, occ_next};
        q_ext   = {32'd0, qcnt_next};
        h_ext   = {32'd0, hcnt_next};
        e_ext   = {32'd0, ecnt_next};
        p_ext   = {64'd0, hit_payload};
        m_data_next.hit            = (is_lookup || is_insert) && found;
        m_data_next.entry_out      = (is_lookup && found) ? p_ext[63:0] : 64'd0;
        m_data_next.evicted        = evict;
        m_data_next.occupancy      = occ_ext[6:0];
        m_data_next.query_count    = q_ext[31:0];
        m_data_next.hit_count      = h_ext[31:0];
        m_data_next.eviction_count = e_ext[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            qcnt_reg    <= '0;
            hcnt_reg    <= '0;
            ecnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (xfer) begin
                occ_reg  <= occ_next;
                qcnt_reg <= qcnt_next;
                hcnt_reg <= hcnt_next;
                ecnt_reg <= ecnt_next;
            end
            if (xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (xfer) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/lkv_cell.sv =====
// One slot of the recency-ordered chain: key, payload, valid.
// Depends on lkv_pkg.
module lkv_cell #(
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lkv_pkg::cell_ctrl_t     ctrl,
    input  logic                    kill,
    input  logic [63:0]             query_key,
    input  logic                    prev_valid,
    input  logic [63:0]             prev_key,
    input  logic [PAYLOAD_BITS-1:0] prev_payload,
    input  logic                    found_in,
    output logic                    found_out,
    output logic                    match,
    output logic                    valid,
    output logic [63:0]             key,
    output logic [PAYLOAD_BITS-1:0] payload
);
    import lkv_pkg::*;

    logic                    valid_reg, valid_next;
    logic [63:0]             key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                    take;

    assign match     = valid_reg && (key_reg == query_key);
    // a hit at this slot or deeper: this slot moves down one place
    assign found_out = match | found_in;
    assign take      = ctrl.take_all | (ctrl.take_hit & found_out);

    always_comb begin
        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        if (take) begin
            valid_next   = prev_valid;
            key_next     = prev_key;
            payload_next = prev_payload;
        end
        if (kill || ctrl.clear) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign valid   = valid_reg;
    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

// ===== rtl/lkv_checker.sv =====
// Port-level checker for the LRU key/value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache_top_macros.svh.
`include "lru_key_value_cache_top_macros.svh"

module lkv_checker #(
    parameter int CAPACITY = 64
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input lkv_pkg::out_item_t m_data
);
    import lkv_pkg::*;

    `LKV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `LKV_ASSERT_IMPL(a_hit_no_evict, aclk, aresetn, m_valid && m_data.hit, !m_data.evicted, "hit and eviction together")
    `LKV_ASSERT_IMPL(a_payload_needs_hit, aclk, aresetn, m_valid && (m_data.entry_out != 64'd0), m_data.hit, "payload without hit")
    `LKV_ASSERT_IMPL(a_occ_bound, aclk, aresetn, m_valid && (CAPACITY < 128), 32'(m_data.occupancy) <= 32'(CAPACITY), "occupancy above capacity")
    `LKV_ASSERT_IMPL(a_stall_blocks, aclk, aresetn, m_valid && !m_ready, !s_ready, "input ready while result stalled")

endmodule

bind lru_key_value_cache_top lkv_checker #(.CAPACITY(CAPACITY)) u_lkv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/lru_key_value_cache_top_tb.sv =====
// Testbench for lru_key_value_cache_top: directed and random cache operations
// checked against an in-bench LRU model. Depends on lkv_pkg and the cache RTL.
`timescale 1ns / 100ps

module lru_key_value_cache_top_tb;
    import lkv_pkg::*;

    localparam int SLOTS = 64;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    lru_key_value_cache_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // model state
    logic        mdl_valid [SLOTS];
    logic [63:0] mdl_key [SLOTS];
    logic [63:0] mdl_payload [SLOTS];
    int unsigned mdl_rank [SLOTS];
    int unsigned mdl_total;
    logic [31:0] mdl_queries, mdl_hits, mdl_evicts;
    logic [6:0]  mdl_capacity;

    out_item_t   expected_q[$];
    int          error_count = 0;
    int          result_count = 0;
    int          items_sent = 0;
    bit          rx_burst_stall = 1'b0;
    logic [63:0] key_pool [16];

    function automatic logic [31:0] sat_up(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (mdl_valid[i] && mdl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void promote(int idx);
        int unsigned r;
        r = mdl_rank[idx];
        for (int i = 0; i < SLOTS; i++)
            if (mdl_valid[i] && mdl_rank[i] < r) mdl_rank[i]++;
        mdl_rank[idx] = 0;
    endfunction

    function automatic out_item_t cache_predict(in_item_t it);
        out_item_t r;
        int idx;
        int unsigned cap;
        bit stored;
        r = '0;
        cap = (mdl_capacity > SLOTS) ? SLOTS : mdl_capacity;
        case (kind_t'(it.kind))
            KIND_LOOKUP: begin
                mdl_queries = sat_up(mdl_queries);
                idx = find_slot(it.key);
                if (idx >= 0) begin
                    r.hit = 1'b1;
                    r.entry_out = mdl_payload[idx];
                    promote(idx);
                    mdl_hits = sat_up(mdl_hits);
                end
            end
            KIND_INSERT: begin
                idx = find_slot(it.key);
                if (idx >= 0) begin
                    r.hit = 1'b1;
                    mdl_payload[idx] = it.entry_in;
                    promote(idx);
                end else begin
                    stored = 1'b1;
                    if (mdl_total + 1 > cap) begin
                        r.evicted = 1'b1;
                        mdl_evicts = sat_up(mdl_evicts);
                        if (mdl_total == 0) stored = 1'b0;
                        else begin
                            for (int i = 0; i < SLOTS; i++)
                                if (mdl_valid[i] && mdl_rank[i] == mdl_total - 1) begin
                                    mdl_valid[i] = 1'b0;
                                    mdl_total--;
                                    break;
                                end
                        end
                    end
                    if (stored) begin
                        for (int i = 0; i < SLOTS; i++)
                            if (mdl_valid[i]) mdl_rank[i]++;
                        for (int i = 0; i < SLOTS; i++)
                            if (!mdl_valid[i]) begin
                                mdl_valid[i] = 1'b1;
                                mdl_key[i] = it.key;
                                mdl_payload[i] = it.entry_in;
                                mdl_rank[i] = 0;
                                mdl_total++;
                                break;
                            end
                    end
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) mdl_valid[i] = 1'b0;
                mdl_total = 0;
                mdl_queries = '0;
                mdl_hits = '0;
                mdl_evicts = '0;
            end
            default: ;
        endcase
        r.occupancy = mdl_total[6:0];
        r.query_count = mdl_queries;
        r.hit_count = mdl_hits;
        r.eviction_count = mdl_evicts;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", result_count, what, got, want);
        error_count++;
    endtask

    // s_valid drops only when the sender actually idles
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 0) n = 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_item(kind_t k, logic [63:0] key, logic [63:0] payload);
        in_item_t it;
        it.kind = k;
        it.key = key;
        it.entry_in = payload;
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.insert(expected_q.size(), cache_predict(it));
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [6:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mdl_capacity = v;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", 64'd0, 64'd0);
            end else begin
                out_item_t e;
                e = expected_q[0];
                expected_q.delete(0);
                if (m_data.hit !== e.hit)
                    report_mismatch("hit", 64'(m_data.hit), 64'(e.hit));
                if (m_data.entry_out !== e.entry_out)
                    report_mismatch("entry_out", m_data.entry_out, e.entry_out);
                if (m_data.evicted !== e.evicted)
                    report_mismatch("evicted", 64'(m_data.evicted), 64'(e.evicted));
                if (m_data.occupancy !== e.occupancy)
                    report_mismatch("occupancy", 64'(m_data.occupancy), 64'(e.occupancy));
                if (m_data.query_count !== e.query_count)
                    report_mismatch("query_count", 64'(m_data.query_count),
                                    64'(e.query_count));
                if (m_data.hit_count !== e.hit_count)
                    report_mismatch("hit_count", 64'(m_data.hit_count), 64'(e.hit_count));
                if (m_data.eviction_count !== e.eviction_count)
                    report_mismatch("eviction_count", 64'(m_data.eviction_count),
                                    64'(e.eviction_count));
            end
            result_count++;
        end
    end

    // receiver ready: random stalls, plus one long hold-off on request
    int rx_stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_burst_stall) begin
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                                         : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_item(KIND_LOOKUP, 64'h0, 64'h0);
        send_item(KIND_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(KIND_LOOKUP, 64'h0, 64'h1234);
        send_item(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(KIND_INSERT, 64'h0, 64'hA5A5_5A5A_0F0F_F0F0);
        send_item(KIND_LOOKUP, 64'h0, 64'h0);
        send_item(KIND_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_CLEAR, 64'h0, 64'h0);
        send_item(KIND_LOOKUP, 64'h0, 64'h0);
        // zero capacity on an empty store: insert evicted at once
        write_capacity(7'd0);
        send_item(KIND_INSERT, 64'h55, 64'h66);
        send_item(KIND_LOOKUP, 64'h55, 64'h0);
        // capacity above the store size clamps
        write_capacity(7'd127);
        for (int i = 0; i < 6; i++) send_item(KIND_INSERT, 64'h100 + i, 64'h200 + i);
        // lowering below occupancy evicts one per new key
        write_capacity(7'd2);
        send_item(KIND_INSERT, 64'h300, 64'h1);
        send_item(KIND_INSERT, 64'h301, 64'h2);
        send_item(KIND_LOOKUP, 64'h100, 64'h0);
        send_item(KIND_LOOKUP, 64'h105, 64'h0);
        send_item(KIND_CLEAR, 64'h0, 64'h0);
    endtask

    task automatic test_random(int count, int keys_used);
        kind_t k;
        logic [63:0] key, pl;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) k = KIND_LOOKUP;
            else if (sel < 94) k = KIND_INSERT;
            else if (sel < 97) k = KIND_NOP;
            else k = KIND_CLEAR;
            if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
            else key = key_pool[$urandom_range(0, keys_used - 1)];
            pl = {$urandom, $urandom};
            send_item(k, key, pl);
            idle_gap();
        end
    endtask

    task automatic test_backpressure();
        drain();
        rx_burst_stall = 1'b1;
        fork
            begin
                for (int i = 0; i < 8; i++)
                    send_item(KIND_INSERT, key_pool[i], {$urandom, $urandom});
            end
            begin
                repeat (60) @(posedge aclk);
                rx_burst_stall = 1'b0;
            end
        join
        drain();
    endtask

    task automatic test_capacity_sweep();
        logic [6:0] caps [6] = '{7'd1, 7'd3, 7'd64, 7'd0, 7'd8, 7'd100};
        foreach (caps[i]) begin
            write_capacity(caps[i]);
            test_random(230, 16);
        end
        write_capacity(7'd64);
        // many keys fill the whole store
        for (int i = 0; i < 70; i++) send_item(KIND_INSERT, {$urandom, $urandom}, 64'(i));
        test_random(300, 16);
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'h0;
        key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < SLOTS; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_key[i] = '0;
            mdl_payload[i] = '0;
            mdl_rank[i] = 0;
        end
        mdl_total = 0;
        mdl_queries = '0;
        mdl_hits = '0;
        mdl_evicts = '0;
        mdl_capacity = CAP_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_capacity_sweep();
        drain();
        repeat (20) @(posedge aclk);
        $display("Sent %0d operations, checked %0d results over capacities 0..127,",
                 items_sent, result_count);
        $display("including clears, unused kinds and a long receiver stall.");
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("lru_key_value_cache_top_tb passed");
        end else begin
            $display("lru_key_value_cache_top_tb failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for results");
        $display("lru_key_value_cache_top_tb failed");
        $finish;
    end
endmodule

// ===== lru_key_value_cache_top.f =====
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_top.sv
rtl/lkv_checker.sv
tb/sv/lru_key_value_cache_top_tb.sv
